// ----- rtl/ssq_pkg.sv -----
// shared types and constants of the shift switch qualifier
package ssq_pkg;

  // field widths
  localparam int unsigned SMP_W  = 12;
  localparam int unsigned REL_W  = 8;
  localparam int unsigned CNT_W  = 10;
  localparam int unsigned PS_W   = 2;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned WDAT_W = 12;

  // poll state codes
  localparam logic [PS_W-1:0] PS_NONE = 2'd0;
  localparam logic [PS_W-1:0] PS_DOWN = 2'd1;
  localparam logic [PS_W-1:0] PS_UP   = 2'd2;
  localparam logic [PS_W-1:0] PS_EXEC = 2'd3;

  // op codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_REARM  = 1'b1;

  // register indexes
  localparam logic [IDX_W-1:0] REG_RELEASE_THR = 8'd0;
  localparam logic [IDX_W-1:0] REG_PRESS_THR   = 8'd1;
  localparam logic [IDX_W-1:0] REG_LOW_LIMIT   = 8'd2;
  localparam logic [IDX_W-1:0] REG_PRESS_LIMIT = 8'd3;

  // register reset values
  localparam logic [SMP_W-1:0] RST_RELEASE_THR = 12'd1000;
  localparam logic [SMP_W-1:0] RST_PRESS_THR   = 12'd3000;
  localparam logic [REL_W-1:0] RST_LOW_LIMIT   = 8'd20;
  localparam logic [CNT_W-1:0] RST_PRESS_LIMIT = 10'd10;

  // saturation limits
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [REL_W-1:0] REL_MAX = '1;

  typedef struct packed {
    logic             op;
    logic [SMP_W-1:0] adc_down;
    logic [SMP_W-1:0] adc_up;
    logic             shifter_idle;
  } in_beat_t;

  typedef struct packed {
    logic            request_valid;
    logic            request_up;
    logic [PS_W-1:0] poll_status;
  } out_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [WDAT_W-1:0] wdata;
  } cfg_beat_t;

  typedef struct packed {
    logic [SMP_W-1:0] release_threshold;
    logic [SMP_W-1:0] press_threshold;
    logic [REL_W-1:0] low_limit;
    logic [CNT_W-1:0] press_limit;
  } cfg_regs_t;

endpackage

// ----- rtl/ssq_if.sv -----
// valid/ready channel interfaces of the shift switch qualifier

interface ssq_in_if;
  logic               valid;
  logic               ready;
  ssq_pkg::in_beat_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ssq_out_if;
  logic               valid;
  logic               ready;
  ssq_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ssq_cfg_if;
  logic               valid;
  logic               ready;
  ssq_pkg::cfg_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ssq_core.sv -----
// qualification state and per-tick update of the shift switch qualifier
module ssq_core #(
  parameter int unsigned ADC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  ssq_pkg::in_beat_t   beat,
  input  ssq_pkg::cfg_regs_t  cfg,
  output ssq_pkg::out_beat_t  res
);

  localparam int unsigned CMP_W =
    (ADC_BITS < ssq_pkg::SMP_W) ? ADC_BITS : ssq_pkg::SMP_W;

  logic                       await_release_r, await_release_nxt;
  logic [ssq_pkg::REL_W-1:0]  release_count_r, release_count_nxt;
  logic [ssq_pkg::PS_W-1:0]   poll_state_r, poll_state_nxt;
  logic [ssq_pkg::CNT_W-1:0]  window_count_r [2];
  logic [ssq_pkg::CNT_W-1:0]  window_count_nxt [2];
  logic [ssq_pkg::CNT_W-1:0]  high_run_r [2];
  logic [ssq_pkg::CNT_W-1:0]  high_run_nxt [2];

  // masked operands
  logic [CMP_W-1:0] smp_down, smp_up, rel_thr, prs_thr;
  assign smp_down = beat.adc_down[CMP_W-1:0];
  assign smp_up   = beat.adc_up[CMP_W-1:0];
  assign rel_thr  = cfg.release_threshold[CMP_W-1:0];
  assign prs_thr  = cfg.press_threshold[CMP_W-1:0];

  // poll then process
  always_comb begin
    logic [ssq_pkg::PS_W-1:0]  ps;
    logic [ssq_pkg::REL_W-1:0] rc_inc;
    logic                      id;
    logic                      hit;
    logic [ssq_pkg::CNT_W-1:0] wc, hr;
    logic                      pressed;
    await_release_nxt   = await_release_r;
    release_count_nxt   = release_count_r;
    window_count_nxt[0] = window_count_r[0];
    window_count_nxt[1] = window_count_r[1];
    high_run_nxt[0]     = high_run_r[0];
    high_run_nxt[1]     = high_run_r[1];
    res                 = '0;
    ps                  = poll_state_r;
    rc_inc              = '0;
    id                  = 1'b0;
    hit                 = 1'b0;
    wc                  = '0;
    hr                  = '0;
    pressed             = 1'b0;
    if (beat.op == ssq_pkg::OP_REARM) begin
      ps = ssq_pkg::PS_NONE;
    end else begin
      // poll
      if (beat.shifter_idle && poll_state_r == ssq_pkg::PS_NONE) begin
        if (await_release_r) begin
          if (smp_down < rel_thr && smp_up < rel_thr) begin
            rc_inc = (release_count_r == ssq_pkg::REL_MAX) ? release_count_r
                                                            : release_count_r + 1'b1;
            if (rc_inc > cfg.low_limit) begin
              release_count_nxt = '0;
              await_release_nxt = 1'b0;
            end else begin
              release_count_nxt = rc_inc;
            end
          end else begin
            release_count_nxt = '0;
          end
        end else if (smp_down > prs_thr) begin
          ps = ssq_pkg::PS_DOWN;
        end else if (smp_up > prs_thr) begin
          ps = ssq_pkg::PS_UP;
        end
      end
      // process the latched switch
      if (ps == ssq_pkg::PS_DOWN || ps == ssq_pkg::PS_UP) begin
        id  = (ps == ssq_pkg::PS_UP);
        hit = id ? (smp_up > prs_thr) : (smp_down > prs_thr);
        wc  = window_count_r[id];
        hr  = high_run_r[id];
        if (wc <= cfg.press_limit) begin
          window_count_nxt[id] = (wc == ssq_pkg::CNT_MAX) ? wc : wc + 1'b1;
          if (hit) begin
            hr = (hr == ssq_pkg::CNT_MAX) ? hr : hr + 1'b1;
          end else begin
            hr = '0;
          end
          high_run_nxt[id] = hr;
          pressed = (hr >= cfg.press_limit);
        end else begin
          window_count_nxt[0] = '0;
          window_count_nxt[1] = '0;
          high_run_nxt[0]     = '0;
          high_run_nxt[1]     = '0;
          ps                  = ssq_pkg::PS_NONE;
        end
        if (pressed) begin
          await_release_nxt   = 1'b1;
          ps                  = ssq_pkg::PS_EXEC;
          window_count_nxt[0] = '0;
          window_count_nxt[1] = '0;
          high_run_nxt[0]     = '0;
          high_run_nxt[1]     = '0;
          res.request_valid   = 1'b1;
          res.request_up      = id;
        end
      end
    end
    poll_state_nxt  = ps;
    res.poll_status = ps;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_release_r   <= 1'b1;
      release_count_r   <= '0;
      poll_state_r      <= ssq_pkg::PS_NONE;
      window_count_r[0] <= '0;
      window_count_r[1] <= '0;
      high_run_r[0]     <= '0;
      high_run_r[1]     <= '0;
    end else if (step) begin
      await_release_r   <= await_release_nxt;
      release_count_r   <= release_count_nxt;
      poll_state_r      <= poll_state_nxt;
      window_count_r[0] <= window_count_nxt[0];
      window_count_r[1] <= window_count_nxt[1];
      high_run_r[0]     <= high_run_nxt[0];
      high_run_r[1]     <= high_run_nxt[1];
    end
  end

  // re-arm always drops back to polling
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    step && beat.op == ssq_pkg::OP_REARM |=> poll_state_r == ssq_pkg::PS_NONE)
    else $error("re-arm did not clear poll state");

  // executing is left only by re-arm
  a_exec_hold: assert property (@(posedge clk) disable iff (!rst_n)
    poll_state_r == ssq_pkg::PS_EXEC && !(step && beat.op == ssq_pkg::OP_REARM)
    |=> poll_state_r == ssq_pkg::PS_EXEC)
    else $error("left executing state without re-arm");

  // a request rearms the release wait and clears the counters
  a_req_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.request_valid |=> await_release_r && window_count_r[0] == '0 &&
    window_count_r[1] == '0 && high_run_r[0] == '0 && high_run_r[1] == '0)
    else $error("request left stale qualification state");

  // state moves only on a step
  a_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(poll_state_r) && $stable(release_count_r) &&
    $stable(await_release_r))
    else $error("state changed without a step");

endmodule

// ----- rtl/shift_switch_qualifier.sv -----
// top level of the shift switch qualifier: handshakes, registers, result stage
//
//  channel  dir  beat payload                              handshake
//  in_ch    in   op, adc_down, adc_up, shifter_idle        valid/ready
//  out_ch   out  request_valid, request_up, poll_status    valid/ready
//  cfg_ch   in   idx, wdata                                valid/ready, always ready
//
//  one beat per cycle sustained while out_ch is ready; a taken beat reaches out_ch
//  through the input register, then the update and result register
//  the tick update of the qualification state is a single pass of compares and counters
//  rst_n is synchronous and active low; the control, state and configuration registers
//  return to their reset values, the data registers are not reset; a stalled out_ch holds
//  its beat; in_ch keeps taking beats while the input register can drain into the result register
module shift_switch_qualifier #(
  parameter int unsigned ADC_BITS = 12
) (
  input logic        clk,
  input logic        rst_n,
  ssq_in_if.sink     in_ch,
  ssq_out_if.source  out_ch,
  ssq_cfg_if.sink    cfg_ch
);

  ssq_pkg::cfg_regs_t  cfg_r;
  ssq_pkg::in_beat_t   in_data_r;
  logic                in_valid_r;
  ssq_pkg::out_beat_t  out_data_r;
  logic                out_valid_r;
  ssq_pkg::out_beat_t  core_res;
  logic                adv;

  // stage advance when the result register is free or drains
  assign adv          = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || adv;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign cfg_ch.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.release_threshold <= ssq_pkg::RST_RELEASE_THR;
      cfg_r.press_threshold   <= ssq_pkg::RST_PRESS_THR;
      cfg_r.low_limit         <= ssq_pkg::RST_LOW_LIMIT;
      cfg_r.press_limit       <= ssq_pkg::RST_PRESS_LIMIT;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.idx)
        ssq_pkg::REG_RELEASE_THR:
          cfg_r.release_threshold <= cfg_ch.data.wdata[ssq_pkg::SMP_W-1:0];
        ssq_pkg::REG_PRESS_THR:
          cfg_r.press_threshold <= cfg_ch.data.wdata[ssq_pkg::SMP_W-1:0];
        ssq_pkg::REG_LOW_LIMIT:
          cfg_r.low_limit <= cfg_ch.data.wdata[ssq_pkg::REL_W-1:0];
        ssq_pkg::REG_PRESS_LIMIT:
          cfg_r.press_limit <= cfg_ch.data.wdata[ssq_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_data_r <= in_ch.data;
    end
  end

  ssq_core #(
    .ADC_BITS (ADC_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .beat  (in_data_r),
    .cfg   (cfg_r),
    .res   (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= core_res;
    end
  end

endmodule
